@@ rtl/core/glr_pkg.sv @@
`timescale 1ns / 1ps
package glr_pkg;

  localparam int unsigned ColorBits = 24;
  localparam int unsigned ChanBits  = 8;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_e;

  // Classified request handed from front to back
  typedef struct packed {
    logic                 is_load;
    logic [ColorBits-1:0] start_color;
    logic [ColorBits-1:0] end_color;
  } cmd_meta_t;

endpackage

@@ rtl/core/glr_front.sv @@
`timescale 1ns / 1ps
module glr_front #(
  parameter int unsigned CoordBits = 12,
  parameter int unsigned Depth     = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_action_i,
  input  logic [4*CoordBits-1:0]        in_coords_i,
  input  glr_pkg::cmd_meta_t            in_meta_i,
  output logic                          q_valid_o,
  input  logic                          q_ready_i,
  output logic [4*CoordBits-1:0]        q_coords_o,
  output glr_pkg::cmd_meta_t            q_meta_o
);
  import glr_pkg::*;

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [4*CoordBits-1:0] coords_q [Depth];
  cmd_meta_t              meta_q   [Depth];
  logic [PtrBits-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntBits-1:0]     cnt_q, cnt_d;
  logic                   push, pop;
  cmd_meta_t              meta_in;

  // classify: tag loads so the back end needs no decode
  always_comb begin
    meta_in         = in_meta_i;
    meta_in.is_load = (in_action_i == ACT_LOAD);
  end

  assign in_ready_o = (cnt_q != CntBits'(Depth));
  assign q_valid_o  = (cnt_q != '0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;
  assign q_coords_o = coords_q[rd_q];
  assign q_meta_o   = meta_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) wr_d = (wr_q == PtrBits'(Depth - 1)) ? '0 : wr_q + 1'b1;
    if (pop)  rd_d = (rd_q == PtrBits'(Depth - 1)) ? '0 : rd_q + 1'b1;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (!push && pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      coords_q[wr_q] <= in_coords_i;
      meta_q[wr_q]   <= meta_in;
    end
  end

endmodule

@@ rtl/core/glr_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle
module glr_div #(
  parameter int unsigned NumBits = 20,
  parameter int unsigned DenBits = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic               done_o,
  output logic [NumBits-1:0] quot_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] quot_q, quot_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               run_q, run_d, done_q, done_d;
  logic [DenBits+1:0] trial;

  assign trial  = {rem_q, quot_q[NumBits-1]} - {2'b00, den_q};
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      cnt_d  = CntBits'(NumBits);
      run_d  = 1'b1;
    end else if (run_q) begin
      if (!trial[DenBits+1]) begin
        rem_d  = trial[DenBits:0];
        quot_d = {quot_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d  = {rem_q[DenBits-1:0], quot_q[NumBits-1]};
        quot_d = {quot_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) den_q <= den_i;
  end

endmodule

@@ rtl/core/glr_back.sv @@
`timescale 1ns / 1ps
module glr_back #(
  parameter int unsigned CoordBits = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  output logic                   q_ready_o,
  input  logic [4*CoordBits-1:0] q_coords_i,
  input  glr_pkg::cmd_meta_t     q_meta_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CoordBits-1:0]   pixel_x_o,
  output logic [CoordBits-1:0]   pixel_y_o,
  output logic [glr_pkg::ColorBits-1:0] pixel_color_o,
  output logic                   last_o
);
  import glr_pkg::*;

  localparam int unsigned CB  = CoordBits;
  localparam int unsigned EB  = CB + 2;
  localparam int unsigned NB  = ChanBits + CB;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_NEXT, ST_OUT
  } state_e;

  state_e state_q;
  logic signed [CB-1:0] cx_q, cy_q, gx_q, gy_q;
  logic [CB-1:0]        dx_q, dy_q, idx_q, tot_q;
  logic signed [EB-1:0] err_q;
  logic [ColorBits-1:0] c0_q, c1_q, col_q;
  logic                 busy_q, last_q;
  logic [1:0]           ch_q;
  logic signed [CB-1:0] ox_q, oy_q;

  // load-side arithmetic
  logic signed [CB-1:0] lsx, lsy, lgx, lgy;
  logic signed [CB:0]   ldx_s, ldy_s;
  logic [CB-1:0]        ldx, ldy;
  assign lsx   = q_coords_i[CB-1:0];
  assign lsy   = q_coords_i[2*CB-1:CB];
  assign lgx   = q_coords_i[3*CB-1:2*CB];
  assign lgy   = q_coords_i[4*CB-1:3*CB];
  assign ldx_s = {lgx[CB-1], lgx} - {lsx[CB-1], lsx};
  assign ldy_s = {lgy[CB-1], lgy} - {lsy[CB-1], lsy};
  assign ldx   = ldx_s[CB] ? CB'(-ldx_s) : ldx_s[CB-1:0];
  assign ldy   = ldy_s[CB] ? CB'(-ldy_s) : ldy_s[CB-1:0];

  function automatic logic far2(input logic signed [CB-1:0] a, b, c, d);
    logic signed [CB:0] u, v;
    u = {a[CB-1], a} - {b[CB-1], b};
    v = {c[CB-1], c} - {d[CB-1], d};
    return (u > 1) || (u < -1) || (v > 1) || (v < -1);
  endfunction

  // channel select: channel 0 = red (top byte)
  logic [ChanBits-1:0] a_ch, b_ch;
  logic                neg;
  logic [ChanBits-1:0] mag;
  always_comb begin
    case (ch_q)
      2'd0:    begin a_ch = c0_q[23:16]; b_ch = c1_q[23:16]; end
      2'd1:    begin a_ch = c0_q[15:8];  b_ch = c1_q[15:8];  end
      default: begin a_ch = c0_q[7:0];   b_ch = c1_q[7:0];   end
    endcase
    neg = b_ch < a_ch;
    mag = neg ? a_ch - b_ch : b_ch - a_ch;
  end

  // divider: ceil for negative via (m*i + tot - 1) / tot
  logic [NB-1:0] prod_q, dnum;
  logic          neg_q, dstart, ddone;
  logic [NB-1:0] dquot;
  assign dnum = neg_q ? prod_q + NB'(tot_q) - 1'b1 : prod_q;

  glr_div #(.NumBits(NB), .DenBits(CB)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(tot_q),
    .done_o(ddone), .quot_o(dquot)
  );

  logic [ChanBits-1:0] chv;
  assign chv = neg_q ? a_ch - dquot[ChanBits-1:0] : a_ch + dquot[ChanBits-1:0];

  // Bresenham advance; the error swings to about 1.5x the span, so 2*err needs a bit more
  logic signed [EB:0]   e2;
  logic signed [EB-1:0] nerr;
  logic signed [CB-1:0] nx, ny;
  always_comb begin
    e2   = {err_q, 1'b0};
    nerr = err_q;
    nx   = cx_q;
    ny   = cy_q;
    if (e2 > -$signed({2'b00, dy_q})) begin
      nerr = nerr - $signed({2'b00, dy_q});
      nx   = (cx_q < gx_q) ? cx_q + 1'b1 : cx_q - 1'b1;
    end
    if (e2 < $signed({2'b00, dx_q})) begin
      nerr = nerr + $signed({2'b00, dx_q});
      ny   = (cy_q < gy_q) ? cy_q + 1'b1 : cy_q - 1'b1;
    end
  end

  logic go_q;
  assign q_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign pixel_x_o   = ox_q;
  assign pixel_y_o   = oy_q;
  assign pixel_color_o = col_q;
  assign last_o      = last_q;
  assign dstart      = go_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      go_q    <= 1'b0;
      ch_q    <= '0;
      cx_q <= '0; cy_q <= '0; gx_q <= '0; gy_q <= '0;
      dx_q <= '0; dy_q <= '0; err_q <= '0; idx_q <= '0; tot_q <= '0;
      c0_q <= '0; c1_q <= '0;
      prod_q <= '0; neg_q <= 1'b0; col_q <= '0;
      ox_q <= '0; oy_q <= '0; last_q <= 1'b0;
    end else begin
      go_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            if (q_meta_i.is_load) begin
              cx_q <= lsx; cy_q <= lsy; gx_q <= lgx; gy_q <= lgy;
              dx_q <= ldx; dy_q <= ldy;
              err_q <= EB'(ldx) - EB'(ldy);
              idx_q <= '0;
              tot_q <= (ldx > ldy) ? ldx : ldy;
              c0_q <= q_meta_i.start_color;
              c1_q <= q_meta_i.end_color;
              busy_q <= far2(lsx, lgx, lsy, lgy);
            end else if (busy_q) begin
              if (!far2(cx_q, gx_q, cy_q, gy_q)) begin
                busy_q <= 1'b0;
              end else begin
                ch_q    <= '0;
                state_q <= ST_NEXT;
              end
            end
          end
        end
        ST_NEXT: begin
          prod_q  <= NB'(mag) * NB'(idx_q);
          neg_q   <= neg;
          go_q    <= 1'b1;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (ddone) begin
            case (ch_q)
              2'd0:    col_q[23:16] <= chv;
              2'd1:    col_q[15:8]  <= chv;
              default: col_q[7:0]   <= chv;
            endcase
            if (ch_q == 2'd2) begin
              ox_q   <= cx_q; oy_q <= cy_q;
              cx_q   <= nx;   cy_q <= ny;
              err_q  <= nerr;
              idx_q  <= idx_q + 1'b1;
              busy_q <= far2(nx, gx_q, ny, gy_q);
              last_q <= !far2(nx, gx_q, ny, gy_q);
              state_q <= ST_OUT;
            end else begin
              ch_q    <= ch_q + 1'b1;
              state_q <= ST_NEXT;
            end
          end
        end
        ST_OUT: begin
          if (out_ready_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/gradient_line_rasterizer.sv @@
`timescale 1ns / 1ps
// Channel | Dir | tdata (low to high)                                  | tuser
// s_axis  | in  | start_x, start_y, start_color, end_x, end_y, end_color | action
// m_axis  | out | pixel_x, pixel_y, pixel_color                         | -, tlast = last
// A request accepted on s_axis is registered in the request queue before the back end sees it;
// a load is consumed there while the back end is idle. Each pixel is computed by
// one serial divider (COORD_BITS + 8 quotient bits) shared by the three channels.
// Reset is asynchronous and clears control state; no line is loaded after reset.
// A two-entry request queue lets s_axis keep filling while m_axis is stalled.
module gradient_line_rasterizer #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // start_x, start_y, start_color, end_x, end_y, end_color, zero pad
  input  logic [((4*COORD_BITS+48+7)/8)*8-1:0] s_axis_tdata,
  // action
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // pixel_x, pixel_y, pixel_color, zero pad
  output logic [((2*COORD_BITS+24+7)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tlast
);
  import glr_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned OW = ((2*CB+24+7)/8)*8;

  logic [4*CB-1:0] in_coords, q_coords;
  cmd_meta_t       in_meta, q_meta;
  logic            q_valid, q_ready;
  logic [CB-1:0]   px, py;
  logic [ColorBits-1:0] pc;

  assign in_coords = {s_axis_tdata[3*CB+24 +: CB], s_axis_tdata[2*CB+24 +: CB],
                      s_axis_tdata[CB +: CB], s_axis_tdata[0 +: CB]};
  always_comb begin
    in_meta.is_load     = 1'b0;
    in_meta.start_color = s_axis_tdata[2*CB +: ColorBits];
    in_meta.end_color   = s_axis_tdata[4*CB+24 +: ColorBits];
  end

  glr_front #(.CoordBits(CB), .Depth(2)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_action_i(s_axis_tuser), .in_coords_i(in_coords), .in_meta_i(in_meta),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_coords_o(q_coords), .q_meta_o(q_meta)
  );

  glr_back #(.CoordBits(CB)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_coords_i(q_coords), .q_meta_i(q_meta),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .pixel_x_o(px), .pixel_y_o(py), .pixel_color_o(pc), .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = OW'({pc, py, px});

endmodule
